// File: hdl/sde_pkg.sv
// Shared types and codes for the sorted dictionary encoder.
`timescale 1ns / 1ps

package sde_pkg;

   // Field types of the request and response transactions.
   typedef logic [1:0]         mode_type;
   typedef logic signed [31:0] value_type;
   typedef logic [9:0]         code_type;
   typedef logic [10:0]        count_type;
   typedef logic [1:0]         status_type;

   // Request modes.
   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_READ   = 2'd1;
   localparam mode_type MODE_CLEAR  = 2'd2;

   // Response status codes.
   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_FULL  = 2'd1;
   localparam status_type STAT_RANGE = 2'd2;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_SEARCH_RD  = 7'b0000010,
      ST_SEARCH_CMP = 7'b0000100,
      ST_SHIFT      = 7'b0001000,
      ST_FINISH     = 7'b0010000,
      ST_READ_WAIT  = 7'b0100000,
      ST_DONE       = 7'b1000000
   } state_type;

endpackage

// File: hdl/sde_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: hdl/sorted_dictionary_encoder_top.sv
// Order-preserving dictionary encoder: sequencer, dictionary and code memories.
// Readout passes through a read wait state to the done state; clear, refused insert and unused
// mode go straight to the done state. Insert searches the dictionary in ascending order, shifts
// entries and renumbers the stored codes when the value is new, then stores the record's code.
// Throughput: one transaction at a time; the next is accepted in the first response cycle.
// Synchronous active-high reset clears the counts, the limit (to 1024) and the handshake.
`timescale 1ns / 1ps

module sorted_dictionary_encoder_top #(
   parameter int PACKET_DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sde_pkg::mode_type          req_mode,
   input  sde_pkg::value_type         req_value,
   input  logic [9:0]                 req_index,
   // Response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sde_pkg::code_type          rsp_code,
   output sde_pkg::value_type         rsp_dict_value,
   output logic                       rsp_is_new,
   output sde_pkg::count_type         rsp_record_count,
   output sde_pkg::count_type         rsp_dict_count,
   output sde_pkg::status_type        rsp_status,
   // Configuration channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  sde_pkg::count_type         csr_packet_limit
);

   localparam int AW = $clog2(PACKET_DEPTH);
   localparam int CW = $clog2(PACKET_DEPTH + 1);
   localparam int LW = (CW > 11) ? CW : 11;

   // Control state
   sde_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      records_ff, records_in;
   logic [CW-1:0]      distinct_ff, distinct_in;
   sde_pkg::count_type limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               dpend_ff, dpend_in;
   logic               cpend_ff, cpend_in;

   // Working and payload registers
   sde_pkg::value_type  value_ff, value_in;
   logic [9:0]          index_ff, index_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       step_ff, step_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       dwa_ff, dwa_in;
   logic [AW-1:0]       cwa_ff, cwa_in;
   logic [AW-1:0]       res_code_ff, res_code_in;
   sde_pkg::value_type  res_dv_ff, res_dv_in;
   logic                res_new_ff, res_new_in;
   sde_pkg::status_type res_status_ff, res_status_in;
   sde_pkg::code_type   rsp_code_ff, rsp_code_in;
   sde_pkg::value_type  rsp_dv_ff, rsp_dv_in;
   logic                rsp_new_ff, rsp_new_in;
   sde_pkg::count_type  rsp_rcnt_ff, rsp_rcnt_in;
   sde_pkg::count_type  rsp_dcnt_ff, rsp_dcnt_in;
   sde_pkg::status_type rsp_status_ff, rsp_status_in;

   // Memory ports
   logic          dict_we, code_we;
   logic [AW-1:0] dict_wa, dict_ra, code_wa, code_ra;
   logic [31:0]   dict_wd, dict_rd;
   logic [AW-1:0] code_wd, code_rd;

   // Helper values
   logic [LW-1:0] lim_w, depth_w, eff_limit;
   logic          pkt_full;
   logic [CW-1:0] shift_len, dict_src, dict_dst;
   logic          dict_issue, code_issue;
   logic          in_range, in_dict;
   logic          code_bump;

   sde_ram #(.WIDTH(32), .DEPTH(PACKET_DEPTH)) u_dict_ram (
      .clock   (clock),
      .wr_en   (dict_we),
      .wr_addr (dict_wa),
      .wr_data (dict_wd),
      .rd_addr (dict_ra),
      .rd_data (dict_rd)
   );

   sde_ram #(.WIDTH(AW), .DEPTH(PACKET_DEPTH)) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (code_wa),
      .wr_data (code_wd),
      .rd_addr (code_ra),
      .rd_data (code_rd)
   );

   // Effective packet limit: zero acts as one, clipped to the memory depth.
   assign lim_w   = LW'(limit_ff);
   assign depth_w = LW'(PACKET_DEPTH);
   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = LW'(1);
      end else if (lim_w > depth_w) begin
         eff_limit = depth_w;
      end else begin
         eff_limit = lim_w;
      end
   end
   assign pkt_full = (LW'(records_ff) >= eff_limit);

   // Renumber pass: dictionary moves top-down, codes walk bottom-up.
   assign shift_len  = distinct_ff - pos_ff;
   assign dict_src   = distinct_ff - step_ff - CW'(1);
   assign dict_dst   = distinct_ff - step_ff;
   assign dict_issue = (step_ff < shift_len);
   assign code_issue = (step_ff < records_ff);
   assign code_bump  = (code_rd >= pos_ff[AW-1:0]);

   // Readout range checks.
   assign in_range = (LW'(index_ff) < LW'(records_ff));
   assign in_dict  = (LW'(index_ff) < LW'(distinct_ff));

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      records_in    = records_ff;
      distinct_in   = distinct_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      dpend_in      = 1'b0;
      cpend_in      = 1'b0;
      value_in      = value_ff;
      index_in      = index_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      dwa_in        = dwa_ff;
      cwa_in        = cwa_ff;
      res_code_in   = res_code_ff;
      res_dv_in     = res_dv_ff;
      res_new_in    = res_new_ff;
      res_status_in = res_status_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_dv_in     = rsp_dv_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_rcnt_in   = rsp_rcnt_ff;
      rsp_dcnt_in   = rsp_dcnt_ff;
      rsp_status_in = rsp_status_ff;
      dict_ra       = AW'(req_index);
      code_ra       = AW'(req_index);
      dict_we       = 1'b0;
      dict_wa       = dwa_ff;
      dict_wd       = dict_rd;
      code_we       = 1'b0;
      code_wa       = cwa_ff;
      code_wd       = code_rd + AW'(code_bump);

      if (csr_valid && state_ff == sde_pkg::ST_IDLE) begin
         limit_in = csr_packet_limit;
      end

      case (state_ff)
         sde_pkg::ST_IDLE: begin
            if (req_valid) begin
               value_in      = req_value;
               index_in      = req_index;
               res_code_in   = '0;
               res_dv_in     = '0;
               res_new_in    = 1'b0;
               res_status_in = sde_pkg::STAT_OK;
               case (req_mode)
                  sde_pkg::MODE_INSERT: begin
                     if (pkt_full) begin
                        res_dv_in     = req_value;
                        res_status_in = sde_pkg::STAT_FULL;
                        state_in      = sde_pkg::ST_DONE;
                     end else begin
                        pos_in   = '0;
                        state_in = sde_pkg::ST_SEARCH_RD;
                     end
                  end
                  sde_pkg::MODE_READ: begin
                     state_in = sde_pkg::ST_READ_WAIT;
                  end
                  sde_pkg::MODE_CLEAR: begin
                     records_in  = '0;
                     distinct_in = '0;
                     state_in    = sde_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = sde_pkg::ST_DONE;
                  end
               endcase
            end
         end
         sde_pkg::ST_SEARCH_RD: begin
            if (pos_ff == distinct_ff) begin
               found_in = 1'b0;
               step_in  = '0;
               state_in = sde_pkg::ST_SHIFT;
            end else begin
               dict_ra  = pos_ff[AW-1:0];
               state_in = sde_pkg::ST_SEARCH_CMP;
            end
         end
         sde_pkg::ST_SEARCH_CMP: begin
            if ($signed(dict_rd) < value_ff) begin
               pos_in   = pos_ff + CW'(1);
               state_in = sde_pkg::ST_SEARCH_RD;
            end else if (dict_rd == value_ff) begin
               found_in = 1'b1;
               state_in = sde_pkg::ST_FINISH;
            end else begin
               found_in = 1'b0;
               step_in  = '0;
               state_in = sde_pkg::ST_SHIFT;
            end
         end
         sde_pkg::ST_SHIFT: begin
            // Write back what was read last cycle, issue the next reads.
            dict_we  = dpend_ff;
            code_we  = cpend_ff;
            dict_ra  = dict_src[AW-1:0];
            code_ra  = step_ff[AW-1:0];
            dpend_in = dict_issue;
            cpend_in = code_issue;
            dwa_in   = dict_dst[AW-1:0];
            cwa_in   = step_ff[AW-1:0];
            step_in  = step_ff + CW'(1);
            if (!dict_issue && !code_issue) begin
               state_in = sde_pkg::ST_FINISH;
            end
         end
         sde_pkg::ST_FINISH: begin
            // Place the new value and store the record's code.
            if (!found_ff) begin
               dict_we     = 1'b1;
               dict_wa     = pos_ff[AW-1:0];
               dict_wd     = value_ff;
               distinct_in = distinct_ff + CW'(1);
            end
            code_we       = 1'b1;
            code_wa       = records_ff[AW-1:0];
            code_wd       = pos_ff[AW-1:0];
            records_in    = records_ff + CW'(1);
            res_code_in   = pos_ff[AW-1:0];
            res_dv_in     = value_ff;
            res_new_in    = !found_ff;
            res_status_in = sde_pkg::STAT_OK;
            state_in      = sde_pkg::ST_DONE;
         end
         sde_pkg::ST_READ_WAIT: begin
            res_new_in = 1'b0;
            if (in_range) begin
               res_code_in   = code_rd;
               res_dv_in     = in_dict ? $signed(dict_rd) : '0;
               res_status_in = sde_pkg::STAT_OK;
            end else begin
               res_code_in   = '0;
               res_dv_in     = '0;
               res_status_in = sde_pkg::STAT_RANGE;
            end
            state_in = sde_pkg::ST_DONE;
         end
         sde_pkg::ST_DONE: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = sde_pkg::code_type'(res_code_ff);
               rsp_dv_in     = res_dv_ff;
               rsp_new_in    = res_new_ff;
               rsp_rcnt_in   = sde_pkg::count_type'(records_ff);
               rsp_dcnt_in   = sde_pkg::count_type'(distinct_ff);
               rsp_status_in = res_status_ff;
               state_in      = sde_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sde_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sde_pkg::ST_IDLE;
         records_ff   <= '0;
         distinct_ff  <= '0;
         limit_ff     <= 11'd1024;
         rsp_valid_ff <= 1'b0;
         dpend_ff     <= 1'b0;
         cpend_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         records_ff   <= records_in;
         distinct_ff  <= distinct_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         dpend_ff     <= dpend_in;
         cpend_ff     <= cpend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      index_ff      <= index_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      found_ff      <= found_in;
      dwa_ff        <= dwa_in;
      cwa_ff        <= cwa_in;
      res_code_ff   <= res_code_in;
      res_dv_ff     <= res_dv_in;
      res_new_ff    <= res_new_in;
      res_status_ff <= res_status_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_dv_ff     <= rsp_dv_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_rcnt_ff   <= rsp_rcnt_in;
      rsp_dcnt_ff   <= rsp_dcnt_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Ports
   assign req_stall        = (state_ff != sde_pkg::ST_IDLE);
   assign csr_ready        = (state_ff == sde_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code         = rsp_code_ff;
   assign rsp_dict_value   = rsp_dv_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_record_count = rsp_rcnt_ff;
   assign rsp_dict_count   = rsp_dcnt_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   // The dictionary never holds more values than there are records.
   a_distinct_le_records: assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= records_ff)
      else $error("dictionary count exceeds record count");

   // The record count never passes the memory depth.
   a_records_bounded: assert property (@(posedge clock) disable iff (reset)
      LW'(records_ff) <= depth_w)
      else $error("record count beyond packet depth");

   // A response is only raised from the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == sde_pkg::ST_DONE))
      else $error("response raised outside the done state");

   // Pending renumber writes exist only during the shift pass.
   a_pend_in_shift: assert property (@(posedge clock) disable iff (reset)
      (dpend_ff || cpend_ff) |-> state_ff == sde_pkg::ST_SHIFT)
      else $error("renumber write pending outside the shift pass");
`endif

endmodule

// File: verif/sorted_dictionary_encoder_top_tb.sv
// Self-checking testbench for the sorted dictionary encoder top level.
`timescale 1ns / 1ps

module sorted_dictionary_encoder_top_tb;

   localparam int DICT_DEPTH      = 1024;
   localparam int CLOCK_PERIOD    = 12;
   localparam int CYCLE_LIMIT     = 8_000_000;
   localparam int DRAIN_CYCLES    = 3200;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int REPORT_LIMIT    = 10;
   localparam sde_pkg::mode_type MODE_UNUSED = 2'd3;

   // One response transaction, field by field.
   typedef struct packed {
      sde_pkg::code_type   code;
      sde_pkg::value_type  dict_value;
      logic                is_new;
      sde_pkg::count_type  record_count;
      sde_pkg::count_type  dict_count;
      sde_pkg::status_type status;
   } encoder_result_type;

   // Shadow copy of the dictionary and record codes, plus the queue of pending responses.
   class encoder_scoreboard;
      sde_pkg::value_type dict_values[DICT_DEPTH];
      sde_pkg::code_type  record_codes[DICT_DEPTH];
      int                 records;
      int                 distinct;
      sde_pkg::count_type packet_limit;
      encoder_result_type expected_q[$];
      int unsigned        mismatches;

      function new();
         records      = 0;
         distinct     = 0;
         packet_limit = 11'd1024;
         mismatches   = 0;
      endfunction

      function void set_limit(sde_pkg::count_type limit);
         packet_limit = limit;
      endfunction

      // Applies one accepted request transaction and queues the response it must produce.
      function void note_request(sde_pkg::mode_type mode, sde_pkg::value_type value,
                                 logic [9:0] index);
         encoder_result_type res;
         int                 eff_limit;
         int                 pos;
         int                 i;
         bit                 found;
         res = '0;
         case (mode)
            sde_pkg::MODE_INSERT: begin
               eff_limit = (packet_limit == 0) ? 1 : int'(packet_limit);
               if (eff_limit > DICT_DEPTH) eff_limit = DICT_DEPTH;
               res.dict_value = value;
               if (records >= eff_limit) begin
                  res.status = sde_pkg::STAT_FULL;
               end else begin
                  // Ascending signed search for the slot of this value.
                  pos = 0;
                  while (pos < distinct && dict_values[pos] < value) pos++;
                  found = (pos < distinct) && (dict_values[pos] == value);
                  if (!found) begin
                     // Open the slot and renumber every record at or above it.
                     for (i = distinct; i > pos; i--) dict_values[i] = dict_values[i - 1];
                     dict_values[pos] = value;
                     distinct++;
                     for (i = 0; i < records; i++)
                        if (record_codes[i] >= pos) record_codes[i] = record_codes[i] + 1'b1;
                  end
                  record_codes[records] = sde_pkg::code_type'(pos);
                  records++;
                  res.code   = sde_pkg::code_type'(pos);
                  res.is_new = !found;
               end
            end
            sde_pkg::MODE_READ: begin
               if (index < records) begin
                  res.code = record_codes[index];
                  if (index < distinct) res.dict_value = dict_values[index];
               end else begin
                  res.status = sde_pkg::STAT_RANGE;
               end
            end
            sde_pkg::MODE_CLEAR: begin
               records  = 0;
               distinct = 0;
            end
            default: begin
            end
         endcase
         res.record_count = sde_pkg::count_type'(records);
         res.dict_count   = sde_pkg::count_type'(distinct);
         expected_q = {expected_q, res};
      endfunction

      // Compares one accepted response transaction with the oldest pending one.
      function void check_response(encoder_result_type got);
         encoder_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: code %0d value %0d new %0d counts %0d/%0d st %0d",
                        got.code, got.dict_value, got.is_new, got.record_count,
                        got.dict_count, got.status);
            return;
         end
         want = expected_q.pop_front();
         if (got.code !== want.code || got.dict_value !== want.dict_value ||
             got.is_new !== want.is_new || got.record_count !== want.record_count ||
             got.dict_count !== want.dict_count || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $write("response error: expected code %0d value %0d new %0d counts %0d/%0d ",
                      want.code, want.dict_value, want.is_new, want.record_count,
                      want.dict_count);
               $display("st %0d, got code %0d value %0d new %0d counts %0d/%0d st %0d",
                        want.status, got.code, got.dict_value, got.is_new,
                        got.record_count, got.dict_count, got.status);
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   sde_pkg::mode_type   req_mode;
   sde_pkg::value_type  req_value;
   logic [9:0]          req_index;
   logic                rsp_valid;
   logic                rsp_stall;
   sde_pkg::code_type   rsp_code;
   sde_pkg::value_type  rsp_dict_value;
   logic                rsp_is_new;
   sde_pkg::count_type  rsp_record_count;
   sde_pkg::count_type  rsp_dict_count;
   sde_pkg::status_type rsp_status;
   logic                csr_valid;
   logic                csr_ready;
   sde_pkg::count_type  csr_packet_limit;

   bit idle_on;
   bit hold_off_request;

   encoder_scoreboard sb = new();

   sorted_dictionary_encoder_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .req_index        (req_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code         (rsp_code),
      .rsp_dict_value   (rsp_dict_value),
      .rsp_is_new       (rsp_is_new),
      .rsp_record_count (rsp_record_count),
      .rsp_dict_count   (rsp_dict_count),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_packet_limit (csr_packet_limit)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Response side stall: random short bursts, and one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = int'($urandom_range(1, 7)) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted response transaction is checked against the shadow model.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_code, rsp_dict_value, rsp_is_new, rsp_record_count,
                            rsp_dict_count, rsp_status});
   end

   // Hang guard.
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_dictionary_encoder_top: mismatch");
      $finish;
   end

   // Offers one request transaction and returns at the falling edge after it is taken.
   // Valid stays high on return so that back-to-back transactions need no gap.
   task automatic send_request(sde_pkg::mode_type mode, sde_pkg::value_type value,
                               logic [9:0] index);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = int'($urandom_range(1, 7));
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      req_index <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(mode, value, index);
      @(negedge clock);
   endtask

   // Writes the packet limit once every pending response has come back.
   task automatic write_limit(sde_pkg::count_type limit);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      csr_valid        <= 1'b1;
      csr_packet_limit <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_limit(limit);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random traffic at one limit: mostly inserts drawn from a small value pool so that
   // duplicates and renumbering are frequent, plus readouts near the record count.
   task automatic run_phase(sde_pkg::count_type limit, int items, bit idling, int clear_pct,
                            bit pressure);
      sde_pkg::value_type pool_base;
      sde_pkg::mode_type  mode;
      sde_pkg::value_type value;
      logic [9:0]         index;
      int                 roll;
      int                 index_top;
      int                 n;
      write_limit(limit);
      idle_on   = idling;
      pool_base = $urandom;
      if (pressure) hold_off_request = 1'b1;
      for (n = 0; n < items; n++) begin
         roll = int'($urandom_range(0, 99));
         if (roll < clear_pct) mode = sde_pkg::MODE_CLEAR;
         else if (roll < clear_pct + 3) mode = MODE_UNUSED;
         else if (roll < 62) mode = sde_pkg::MODE_INSERT;
         else mode = sde_pkg::MODE_READ;

         roll = int'($urandom_range(0, 99));
         if (roll < 45) begin
            value = pool_base + $urandom_range(0, 15);
         end else if (roll < 60) begin
            case ($urandom_range(0, 5))
               0:       value = 32'sh8000_0000;
               1:       value = 32'sh7fff_ffff;
               2:       value = 32'sh0000_0000;
               3:       value = -32'sd1;
               4:       value = 32'sh8000_0001;
               default: value = 32'sh7fff_fffe;
            endcase
         end else begin
            value = $urandom;
         end

         index_top = (sb.records + 1 > 1023) ? 1023 : sb.records + 1;
         if ($urandom_range(0, 9) < 7) index = 10'($urandom_range(0, index_top));
         else index = 10'($urandom_range(0, 1023));

         send_request(mode, value, index);
      end
   endtask

   // Reset, directed cases, then random phases over several limits.
   initial begin
      int k;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = sde_pkg::MODE_INSERT;
      req_value        = '0;
      req_index        = '0;
      csr_valid        = 1'b0;
      csr_packet_limit = 11'd1024;
      idle_on          = 1'b1;
      hold_off_request = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Readout of an empty packet, then extremes, duplicates and a middle insert.
      send_request(sde_pkg::MODE_READ, 32'sd0, 10'd0);
      send_request(sde_pkg::MODE_INSERT, 32'sd0, 10'd0);
      send_request(sde_pkg::MODE_INSERT, 32'sh7fff_ffff, 10'h3ff);
      send_request(sde_pkg::MODE_INSERT, 32'sh8000_0000, 10'd0);
      send_request(sde_pkg::MODE_INSERT, -32'sd1, 10'd0);
      send_request(sde_pkg::MODE_INSERT, 32'sd0, 10'd0);
      send_request(sde_pkg::MODE_INSERT, 32'sh7fff_ffff, 10'd0);
      send_request(sde_pkg::MODE_INSERT, 32'sh8000_0000, 10'd0);
      send_request(sde_pkg::MODE_INSERT, 32'sd1, 10'd0);

      // Walk every record; the upper ones lie beyond the dictionary, the last beyond both.
      for (k = 0; k <= 8; k++) send_request(sde_pkg::MODE_READ, 32'sh5555_5555, k[9:0]);
      send_request(sde_pkg::MODE_READ, 32'sd0, 10'h3ff);
      send_request(MODE_UNUSED, 32'shdead_beef, 10'h2aa);
      send_request(sde_pkg::MODE_CLEAR, 32'sd0, 10'd0);
      send_request(sde_pkg::MODE_READ, 32'sd0, 10'd0);

      // A full packet refuses the third insert.
      write_limit(11'd2);
      send_request(sde_pkg::MODE_INSERT, 32'sd16, 10'd0);
      send_request(sde_pkg::MODE_INSERT, 32'sd8, 10'd0);
      send_request(sde_pkg::MODE_INSERT, 32'sd4, 10'd0);
      send_request(sde_pkg::MODE_READ, 32'sd0, 10'd1);
      send_request(sde_pkg::MODE_CLEAR, 32'sd0, 10'd0);

      // Limits out of range at both ends, small and large packets; no idling at the end.
      run_phase(11'd2047, 110, 1'b1, 2, 1'b0);
      run_phase(11'd0,     30, 1'b1, 6, 1'b0);
      run_phase(11'd7,     80, 1'b1, 6, 1'b1);
      run_phase(11'd300,   90, 1'b0, 4, 1'b0);
      run_phase(11'd1,     30, 1'b1, 8, 1'b0);
      run_phase(11'd1024, 130, 1'b1, 2, 1'b0);
      run_phase(11'd40,    80, 1'b0, 4, 1'b0);

      // Drain and let any stray response show up.
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("sorted_dictionary_encoder_top: match");
      else
         $display("sorted_dictionary_encoder_top: mismatch");
      $finish;
   end

endmodule
